// ===== rtl/rsfl_pkg.sv =====
`timescale 1ns / 1ps

package rsfl_pkg;

    // Default sizing of the store
    localparam int SLOT_COUNT_DEF   = 1024;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed port field widths
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 10;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int LIVE_W    = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take the input word and launch the memory reads
        logic commit;   // apply the operation and load the result register
    } t_cmd;

endpackage

// ===== rtl/rsfl_ctrl.sv =====
`timescale 1ns / 1ps

module rsfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rsfl_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, commit;

    // Accept in idle; commit once the result register is free or draining
    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.commit = commit;

endmodule

// ===== rtl/rsfl_datapath.sv =====
`timescale 1ns / 1ps

module rsfl_datapath #(
    parameter int SLOT_COUNT   = rsfl_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BITS = rsfl_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rsfl_pkg::t_cmd                  i_cmd,
    input  logic [rsfl_pkg::OP_W-1:0]       i_opcode,
    input  logic [rsfl_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [rsfl_pkg::PAYLOAD_W-1:0]  i_payload_in,
    output logic [rsfl_pkg::STATUS_W-1:0]   o_status,
    output logic [rsfl_pkg::SLOT_W-1:0]     o_slot_used,
    output logic [rsfl_pkg::PAYLOAD_W-1:0]  o_payload_out,
    output logic                            o_slot_is_removed,
    output logic [rsfl_pkg::LIVE_W-1:0]     o_live_records
);

    localparam int AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int CMPW = (CW > rsfl_pkg::SLOT_W) ? CW : rsfl_pkg::SLOT_W;
    localparam logic [CW-1:0] SLOTS_MAX = CW'(SLOT_COUNT);

    // Memories
    logic [PAYLOAD_BITS-1:0] r_store [SLOT_COUNT];
    logic                    r_marks [SLOT_COUNT];
    logic [CW-1:0]           r_links [SLOT_COUNT];

    // Free list and counters
    logic [CW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_live, n_live;

    // Captured word and read data
    logic [rsfl_pkg::OP_W-1:0]   r_op;
    logic [rsfl_pkg::SLOT_W-1:0] r_idx;
    logic [PAYLOAD_BITS-1:0]     r_pay;
    logic [PAYLOAD_BITS-1:0]     r_rd_pay;
    logic                        r_rd_mark;
    logic [CW-1:0]               r_rd_link;

    // Result register
    logic [rsfl_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [rsfl_pkg::SLOT_W-1:0]    r_slot_out, n_slot_out;
    logic [rsfl_pkg::PAYLOAD_W-1:0] r_pay_out, n_pay_out;
    logic                           r_rm_out, n_rm_out;

    // Write controls
    logic          store_we, mark_we, link_we;
    logic          mark_wd;
    logic [CW-1:0] link_wd;
    logic [CW-1:0] wr_slot;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic          list_empty, store_full, in_range;
    logic [CW-1:0] idx_c;

    // Insert reads at the free head, the others at the addressed slot
    assign rd_addr = (i_opcode == rsfl_pkg::OP_INSERT) ? AW'(r_free_head)
                                                        : AW'(i_slot_index);

    assign idx_c      = CW'(r_idx);
    assign list_empty = (r_free_head >= r_used);
    assign store_full = (r_used == SLOTS_MAX);
    assign in_range   = (CMPW'(r_idx) < CMPW'(r_used));
    assign wr_addr    = AW'(wr_slot);

    // Capture the word on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_idx <= i_slot_index;
            r_pay <= i_payload_in[PAYLOAD_BITS-1:0];
        end
    end

    // Record store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[wr_addr] <= r_pay;
        end
        if (i_cmd.accept) begin
            r_rd_pay <= r_store[rd_addr];
        end
    end

    // Removed marks
    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_marks[wr_addr] <= mark_wd;
        end
        if (i_cmd.accept) begin
            r_rd_mark <= r_marks[rd_addr];
        end
    end

    // Free links
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_links[wr_addr] <= link_wd;
        end
        if (i_cmd.accept) begin
            r_rd_link <= r_links[rd_addr];
        end
    end

    // Decode the operation and work out the next state
    always_comb begin
        n_free_head = r_free_head;
        n_used      = r_used;
        n_live      = r_live;
        n_status    = rsfl_pkg::ST_OK;
        n_slot_out  = r_idx;
        n_pay_out   = '0;
        n_rm_out    = 1'b0;
        store_we    = 1'b0;
        mark_we     = 1'b0;
        link_we     = 1'b0;
        mark_wd     = 1'b0;
        link_wd     = '0;
        wr_slot     = idx_c;
        case (r_op)
            rsfl_pkg::OP_INSERT: begin
                if (list_empty && store_full) begin
                    n_status   = rsfl_pkg::ST_FULL;
                    n_slot_out = '0;
                end else begin
                    if (list_empty) begin
                        // append a fresh slot
                        wr_slot     = r_used;
                        n_used      = r_used + 1'b1;
                        n_free_head = r_used + 1'b1;
                    end else begin
                        // pop the free head, clamp a stale link
                        wr_slot     = r_free_head;
                        n_free_head = (r_rd_link > r_used) ? r_used : r_rd_link;
                    end
                    n_slot_out = rsfl_pkg::SLOT_W'(wr_slot);
                    store_we   = i_cmd.commit;
                    mark_we    = i_cmd.commit;
                    link_we    = i_cmd.commit;
                    n_live     = r_live + 1'b1;
                end
            end
            rsfl_pkg::OP_REMOVE: begin
                if (!in_range) begin
                    n_status = rsfl_pkg::ST_RANGE;
                end else if (!r_rd_mark) begin
                    // push the slot onto the free list
                    mark_wd     = 1'b1;
                    link_wd     = r_free_head;
                    mark_we     = i_cmd.commit;
                    link_we     = i_cmd.commit;
                    n_free_head = idx_c;
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
            end
            rsfl_pkg::OP_READ: begin
                if (!in_range) begin
                    n_status = rsfl_pkg::ST_RANGE;
                end else begin
                    n_pay_out = rsfl_pkg::PAYLOAD_W'(r_rd_pay);
                    n_rm_out  = r_rd_mark;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the free list and counters on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used      <= '0;
            r_live      <= '0;
        end else if (i_cmd.commit) begin
            r_free_head <= n_free_head;
            r_used      <= n_used;
            r_live      <= n_live;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_pay_out  <= n_pay_out;
            r_rm_out   <= n_rm_out;
        end
    end

    logic [rsfl_pkg::LIVE_W-1:0] r_live_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_live_out <= rsfl_pkg::LIVE_W'(n_live);
        end
    end

    assign o_status          = r_status;
    assign o_slot_used       = r_slot_out;
    assign o_payload_out     = r_pay_out;
    assign o_slot_is_removed = r_rm_out;
    assign o_live_records    = r_live_out;

endmodule

// ===== rtl/record_slot_free_list_store_unit.sv =====
`timescale 1ns / 1ps
// The result word is loaded into the output register by the commit that follows the accept
// of its input word, and is held there until it is taken.
// Order: a new word is taken only after the last one commits, since the link, mark and
// payload memories are read into registers at accept and written back at commit.
// A waiting result does not block the next accept; commit waits while the result is held.
// Reset (synchronous): clears the free head, slot and live counters; memories are not cleared.

module record_slot_free_list_store_unit #(
    parameter int SLOT_COUNT   = rsfl_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BITS = rsfl_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rsfl_pkg::OP_W-1:0]       i_opcode,
    input  logic [rsfl_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [rsfl_pkg::PAYLOAD_W-1:0]  i_payload_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rsfl_pkg::STATUS_W-1:0]   o_status,
    output logic [rsfl_pkg::SLOT_W-1:0]     o_slot_used,
    output logic [rsfl_pkg::PAYLOAD_W-1:0]  o_payload_out,
    output logic                            o_slot_is_removed,
    output logic [rsfl_pkg::LIVE_W-1:0]     o_live_records
);

    rsfl_pkg::t_cmd cmd;

    rsfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    rsfl_datapath #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_opcode          (i_opcode),
        .i_slot_index      (i_slot_index),
        .i_payload_in      (i_payload_in),
        .o_status          (o_status),
        .o_slot_used       (o_slot_used),
        .o_payload_out     (o_payload_out),
        .o_slot_is_removed (o_slot_is_removed),
        .o_live_records    (o_live_records)
    );

    // An accept and a commit never share a cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && cmd.commit))
        else $error("accept and commit in the same cycle");

    // After an accept the input side stalls while the word is in flight
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // A result appears only from a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // A commit never overwrites a result still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !cmd.commit)
        else $error("commit overwrote a stalled result");

endmodule
